// ----- rtl/core/ipv4p_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and constants for the dotted-decimal IPv4 address parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  // character classes
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // limits of one dotted part
  localparam logic [1:0] MaxDigits  = 2'd3;
  localparam logic [1:0] PartLast   = 2'd3;
  localparam logic [9:0] OctetLimit = 10'd256;

  // one input beat
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  // one result beat
  typedef struct packed {
    logic       valid_res;
    logic [7:0] octet_first;
    logic [7:0] octet_second;
    logic [7:0] octet_third;
    logic [7:0] octet_fourth;
  } addr_beat_t;

  // running parse state
  typedef struct packed {
    logic [1:0]      part_index;
    logic [1:0]      digit_count;
    logic [9:0]      part_value;
    logic            leading_zero_seen;
    logic            text_started;
    logic            trailing_space_seen;
    logic            error_seen;
    logic [2:0][7:0] octet_store;
  } parse_state_t;

endpackage

// ----- rtl/core/ipv4p_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4p_step
// Next parse state for one character, and the result that the string would
// give if this character were its last one.
// ----------------------------------------------------------------------------
module ipv4p_step (
  input  ipv4p_pkg::parse_state_t state,
  input  logic [7:0]              character,
  output ipv4p_pkg::parse_state_t state_next,
  output ipv4p_pkg::addr_beat_t   result
);

  logic       is_blank;
  logic       is_digit;
  logic       is_dot;
  logic [3:0] digit;
  logic [9:0] value_next;
  logic       done_ok;

  // classify the byte
  assign is_blank = ((character >= ipv4p_pkg::ChTab) && (character <= ipv4p_pkg::ChCr))
                    || (character == ipv4p_pkg::ChSpace);
  assign is_digit = (character >= ipv4p_pkg::ChZero) && (character <= ipv4p_pkg::ChNine);
  assign is_dot   = (character == ipv4p_pkg::ChDot);
  assign digit    = character[3:0];

  // value times ten plus the new digit, kept to 10 bits
  assign value_next = {state.part_value[6:0], 3'b000} + {state.part_value[8:0], 1'b0}
                      + {6'd0, digit};

  // state update
  always_comb begin
    state_next = state;
    if (is_blank) begin
      if (state.text_started) begin
        state_next.trailing_space_seen = 1'b1;
      end
    end else begin
      state_next.text_started = 1'b1;
      if (!state.error_seen) begin
        if (state.trailing_space_seen) begin
          state_next.error_seen = 1'b1;
        end else if (is_digit) begin
          if ((state.digit_count == ipv4p_pkg::MaxDigits) || state.leading_zero_seen) begin
            state_next.error_seen = 1'b1;
          end else begin
            if ((state.digit_count == 2'd0) && (digit == 4'd0)) begin
              state_next.leading_zero_seen = 1'b1;
            end
            state_next.part_value  = value_next;
            state_next.digit_count = state.digit_count + 2'd1;
            if (value_next >= ipv4p_pkg::OctetLimit) begin
              state_next.error_seen = 1'b1;
            end
          end
        end else if (is_dot) begin
          if ((state.digit_count == 2'd0) || (state.part_index == ipv4p_pkg::PartLast)) begin
            state_next.error_seen = 1'b1;
          end else begin
            case (state.part_index)
              2'd0:    state_next.octet_store[0] = state.part_value[7:0];
              2'd1:    state_next.octet_store[1] = state.part_value[7:0];
              default: state_next.octet_store[2] = state.part_value[7:0];
            endcase
            state_next.part_index        = state.part_index + 2'd1;
            state_next.digit_count       = 2'd0;
            state_next.part_value        = 10'd0;
            state_next.leading_zero_seen = 1'b0;
          end
        end else begin
          state_next.error_seen = 1'b1;
        end
      end
    end
  end

  // judge the string as it stands after this byte
  assign done_ok = !state_next.error_seen
                   && (state_next.part_index == ipv4p_pkg::PartLast)
                   && (state_next.digit_count != 2'd0)
                   && (state_next.part_value < ipv4p_pkg::OctetLimit);

  always_comb begin
    result.valid_res    = done_ok;
    result.octet_first  = done_ok ? state_next.octet_store[0] : 8'd0;
    result.octet_second = done_ok ? state_next.octet_store[1] : 8'd0;
    result.octet_third  = done_ok ? state_next.octet_store[2] : 8'd0;
    result.octet_fourth = done_ok ? state_next.part_value[7:0] : 8'd0;
  end

endmodule

// ----- rtl/core/ipv4_dotted_decimal_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_decimal_parser_unit
// Parses a dotted-decimal IPv4 address arriving one character per beat and
// gives one result beat (valid flag and four octets) per string.
//
//   channel | signals                         | beat type
//   --------+---------------------------------+---------------------
//   char    | char_valid, char_stall, char_beat | ipv4p_pkg::char_beat_t
//   addr    | addr_valid, addr_stall, addr_beat | ipv4p_pkg::addr_beat_t
//
// One character is taken every cycle while char_stall is low; the parse state
// register is the only loop and updates in the cycle the character is accepted.
// The result beat is registered into the output register, or into the skid entry while an earlier result waits.
// A two-entry output buffer lets parsing go on while a result waits;
// char_stall rises only when both entries are full.
// Synchronous reset clears the parse state and the output buffer's valid flags.
// ----------------------------------------------------------------------------
module ipv4_dotted_decimal_parser_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  ipv4p_pkg::char_beat_t char_beat,
  output logic                  addr_valid,
  input  logic                  addr_stall,
  output ipv4p_pkg::addr_beat_t addr_beat
);

  ipv4p_pkg::parse_state_t state;
  ipv4p_pkg::parse_state_t state_next;
  ipv4p_pkg::addr_beat_t   step_result;
  ipv4p_pkg::addr_beat_t   skid_beat;
  logic                    skid_valid;
  logic                    char_take;
  logic                    result_push;
  logic                    addr_pop;

  // per-character logic
  ipv4p_step u_step (
    .state      (state),
    .character  (char_beat.character),
    .state_next (state_next),
    .result     (step_result)
  );

  assign char_take   = char_valid && !char_stall;
  assign result_push = char_take && char_beat.last;
  assign addr_pop    = addr_valid && !addr_stall;
  assign char_stall  = skid_valid;

  // parse state, cleared after the last character of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (char_take) begin
      if (char_beat.last) begin
        state <= '0;
      end else begin
        state <= state_next;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (addr_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (result_push) begin
      if (!addr_valid || addr_pop) begin
        addr_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (addr_pop) begin
      addr_valid <= 1'b0;
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (addr_pop) begin
        addr_beat <= skid_beat;
      end
    end else if (result_push) begin
      if (!addr_valid || addr_pop) begin
        addr_beat <= step_result;
      end else begin
        skid_beat <= step_result;
      end
    end
  end

`ifndef SYNTH
  // skid entry only fills behind a waiting output beat
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> addr_valid)
    else $error("skid entry full while output register empty");

  // a finished string leaves a clean parse state
  assert property (@(posedge clk) disable iff (rst)
    (char_take && char_beat.last) |=> (state.part_index == 2'd0 && !state.text_started
                                        && !state.error_seen))
    else $error("parse state not cleared after last character");

  // invalid results carry zero octets
  assert property (@(posedge clk) disable iff (rst)
    (addr_valid && !addr_beat.valid_res) |-> (addr_beat.octet_first == 8'd0
      && addr_beat.octet_second == 8'd0 && addr_beat.octet_third == 8'd0
      && addr_beat.octet_fourth == 8'd0))
    else $error("invalid result with nonzero octets");

  // a leading zero is always the only digit of its part
  assert property (@(posedge clk) disable iff (rst)
    state.leading_zero_seen |-> (state.digit_count == 2'd1 && state.part_value == 10'd0))
    else $error("leading zero flag with other digits");
`endif

endmodule
